@@ sv/gda_pkg.sv @@
// Shared types, constants and calendar functions for the Gregorian date arithmetic block.
package gda_pkg;

   localparam int OFFSET_WIDTH = 16;
   localparam int ACC_W = (OFFSET_WIDTH + 2 > 24) ? OFFSET_WIDTH + 2 : 24;

   localparam int DAYS_YEAR = 365;
   localparam int DAYS_LEAP = 366;
   localparam logic [13:0] YEAR_MIN = 14'd1;
   localparam logic [13:0] YEAR_MAX = 14'd9999;
   localparam logic [3:0] MONTH_FIRST = 4'd1;
   localparam logic [3:0] MONTH_LAST = 4'd12;

   localparam int DIFF_TERMS = 5;
   localparam logic [3:0] DIFF_LAST = 4'(2 * DIFF_TERMS);
   localparam logic [2:0] TERM_YEARS = 3'd0;
   localparam logic [2:0] TERM_DIV4 = 3'd1;
   localparam logic [2:0] TERM_DIV100 = 3'd2;
   localparam logic [2:0] TERM_DIV400 = 3'd3;
   localparam logic [2:0] TERM_MONTH = 3'd4;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef enum logic [1:0] {
      FUNC_ADD  = 2'd0,
      FUNC_SUB  = 2'd1,
      FUNC_DIFF = 2'd2,
      FUNC_BAD  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SUB,
      ST_DIFF,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]              func;
      logic [4:0]              base_day;
      logic [3:0]              base_month;
      logic [13:0]             base_year;
      logic [OFFSET_WIDTH-1:0] offset_days;
      logic [4:0]              other_day;
      logic [3:0]              other_month;
      logic [13:0]             other_year;
   } req_type;

   typedef struct packed {
      logic [4:0]  result_day;
      logic [3:0]  result_month;
      logic [13:0] result_year;
      logic [21:0] day_count;
      logic        error_flag;
   } rsp_type;

   typedef struct packed {
      logic    done;
      rsp_type result;
   } seq_status_type;

   localparam rsp_type RSP_ERROR = '{
      result_day: 5'd0, result_month: 4'd0, result_year: 14'd0,
      day_count: 22'd0, error_flag: 1'b1
   };

   function automatic logic [11:0] div25(input logic [11:0] x);
      logic [24:0] prod;
      begin
         prod = 25'(x) * 25'd5243;
         return {4'd0, prod[24:17]};
      end
   endfunction

   function automatic logic is_leap(input logic [13:0] y);
      logic [11:0] q4;
      logic [11:0] q16;
      logic [11:0] m100;
      logic [11:0] m400;
      logic        div100;
      logic        div400;
      begin
         q4 = y[13:2];
         q16 = {2'd0, y[13:4]};
         m100 = 12'(div25(q4) * 12'd25);
         m400 = 12'(div25(q16) * 12'd25);
         div100 = (y[1:0] == 2'd0) && (m100 == q4);
         div400 = (y[3:0] == 4'd0) && (m400 == q16);
         return (y[1:0] == 2'd0) && (!div100 || div400);
      end
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      begin
         case (m)
            4'd2: return leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            default: return 5'd31;
         endcase
      end
   endfunction

   function automatic logic [8:0] cum_days(input logic [3:0] m);
      begin
         case (m)
            4'd1: return 9'd0;
            4'd2: return 9'd31;
            4'd3: return 9'd59;
            4'd4: return 9'd90;
            4'd5: return 9'd120;
            4'd6: return 9'd151;
            4'd7: return 9'd181;
            4'd8: return 9'd212;
            4'd9: return 9'd243;
            4'd10: return 9'd273;
            4'd11: return 9'd304;
            4'd12: return 9'd334;
            default: return 9'd0;
         endcase
      end
   endfunction

endpackage

@@ sv/gda_if.sv @@
// Valid/ready channel interfaces for the request and response items.
interface gda_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        func;
   logic [4:0]                        base_day;
   logic [3:0]                        base_month;
   logic [13:0]                       base_year;
   logic [gda_pkg::OFFSET_WIDTH-1:0]  offset_days;
   logic [4:0]                        other_day;
   logic [3:0]                        other_month;
   logic [13:0]                       other_year;

   modport source (
      output valid, func, base_day, base_month, base_year, offset_days,
      output other_day, other_month, other_year,
      input ready
   );
   modport sink (
      input valid, func, base_day, base_month, base_year, offset_days,
      input other_day, other_month, other_year,
      output ready
   );
endinterface

interface gda_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  result_day;
   logic [3:0]  result_month;
   logic [13:0] result_year;
   logic [21:0] day_count;
   logic        error_flag;

   modport source (
      output valid, result_day, result_month, result_year, day_count, error_flag,
      input ready
   );
   modport sink (
      input valid, result_day, result_month, result_year, day_count, error_flag,
      output ready
   );
endinterface

@@ sv/gda_alu.sv @@
// Shared add/subtract unit used by every step of the sequencer.
module gda_alu (
   input  gda_pkg::acc_type a,
   input  gda_pkg::acc_type b,
   input  logic             sub,
   output gda_pkg::acc_type sum
);

   always_comb begin
      if (sub) begin
         sum = a - b;
      end else begin
         sum = a + b;
      end
   end

endmodule

@@ sv/gda_seq.sv @@
// Sequencer that steps years, months and serial-day terms through the shared adder.
module gda_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  gda_pkg::req_type         req_item,
   input  logic                     req_fire,
   output logic                     idle,
   output gda_pkg::seq_status_type  status,
   input  logic                     take
);

   localparam int ACC_MSB = gda_pkg::ACC_W - 1;

   gda_pkg::state_type state_ff, state_in;
   gda_pkg::acc_type   acc_ff, acc_in;
   logic [3:0]         month_ff, month_in;
   logic [13:0]        year_ff, year_in;
   logic [3:0]         phase_ff, phase_in;
   gda_pkg::req_type   item_ff, item_in;
   gda_pkg::rsp_type   res_ff, res_in;

   gda_pkg::acc_type   alu_a, alu_b, alu_sum;
   logic               alu_sub;

   logic [13:0]        ly;
   logic               leap;
   gda_pkg::acc_type   ylen, ylen_neg;
   logic [4:0]         dim_cur, dim_prev;
   logic [3:0]         month_prev;
   logic               yjump_add, yjump_sub, mstep_add;

   logic               sel_other;
   logic [2:0]         term_idx;
   logic [13:0]        y_sel, p_sel;
   logic [3:0]         m_sel;
   logic [4:0]         d_sel;
   gda_pkg::acc_type   term;
   logic               term_sub;
   logic               req_err;
   logic [13:0]        year_up, year_dn;

   gda_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .sub (alu_sub),
      .sum (alu_sum)
   );

   always_comb begin
      sel_other = (phase_ff >= 4'(gda_pkg::DIFF_TERMS));
      term_idx = sel_other ? 3'(phase_ff - 4'(gda_pkg::DIFF_TERMS)) : phase_ff[2:0];
      y_sel = sel_other ? item_ff.other_year : item_ff.base_year;
      m_sel = sel_other ? item_ff.other_month : item_ff.base_month;
      d_sel = sel_other ? item_ff.other_day : item_ff.base_day;
      p_sel = 14'(y_sel - 14'd1);
      year_up = 14'(year_ff + 14'd1);
      year_dn = 14'(year_ff - 14'd1);

      case (state_ff)
         gda_pkg::ST_ADD: ly = (month_ff <= 4'd2) ? year_ff : year_up;
         gda_pkg::ST_SUB: ly = (month_ff > 4'd2) ? year_ff : year_dn;
         default: ly = y_sel;
      endcase
      leap = gda_pkg::is_leap(ly);
      ylen = leap ? gda_pkg::acc_type'(gda_pkg::DAYS_LEAP)
                  : gda_pkg::acc_type'(gda_pkg::DAYS_YEAR);
      ylen_neg = leap ? gda_pkg::acc_type'(-gda_pkg::DAYS_LEAP)
                      : gda_pkg::acc_type'(-gda_pkg::DAYS_YEAR);
      month_prev = (month_ff == gda_pkg::MONTH_FIRST) ? gda_pkg::MONTH_LAST
                                                      : 4'(month_ff - 4'd1);
      dim_cur = gda_pkg::month_days(month_ff, leap);
      dim_prev = gda_pkg::month_days(month_prev, leap);
      yjump_add = (acc_ff > ylen);
      yjump_sub = (acc_ff <= ylen_neg);
      mstep_add = (acc_ff > gda_pkg::acc_type'(dim_cur));

      case (term_idx)
         gda_pkg::TERM_YEARS:
            term = gda_pkg::acc_type'(p_sel) * gda_pkg::acc_type'(gda_pkg::DAYS_YEAR);
         gda_pkg::TERM_DIV4:   term = gda_pkg::acc_type'(p_sel[13:2]);
         gda_pkg::TERM_DIV100: term = gda_pkg::acc_type'(gda_pkg::div25(p_sel[13:2]));
         gda_pkg::TERM_DIV400:
            term = gda_pkg::acc_type'(gda_pkg::div25({2'd0, p_sel[13:4]}));
         gda_pkg::TERM_MONTH:
            term = gda_pkg::acc_type'(gda_pkg::cum_days(m_sel))
                 + gda_pkg::acc_type'((m_sel > 4'd2) && leap)
                 + gda_pkg::acc_type'(d_sel);
         default: term = '0;
      endcase
      term_sub = sel_other ^ (term_idx == gda_pkg::TERM_DIV100);

      req_err = (gda_pkg::func_type'(req_item.func) == gda_pkg::FUNC_BAD)
             || !(req_item.base_month inside {[gda_pkg::MONTH_FIRST:gda_pkg::MONTH_LAST]})
             || !(req_item.base_year inside {[gda_pkg::YEAR_MIN:gda_pkg::YEAR_MAX]})
             || ((gda_pkg::func_type'(req_item.func) == gda_pkg::FUNC_DIFF)
                 && (!(req_item.other_month
                       inside {[gda_pkg::MONTH_FIRST:gda_pkg::MONTH_LAST]})
                     || !(req_item.other_year
                          inside {[gda_pkg::YEAR_MIN:gda_pkg::YEAR_MAX]})));
   end

   always_comb begin
      case (state_ff)
         gda_pkg::ST_IDLE: begin
            alu_a = gda_pkg::acc_type'(req_item.base_day);
            alu_b = gda_pkg::acc_type'(req_item.offset_days);
            alu_sub = (gda_pkg::func_type'(req_item.func) == gda_pkg::FUNC_SUB);
         end
         gda_pkg::ST_ADD: begin
            alu_a = acc_ff;
            alu_b = yjump_add ? ylen : gda_pkg::acc_type'(dim_cur);
            alu_sub = 1'b1;
         end
         gda_pkg::ST_SUB: begin
            alu_a = acc_ff;
            alu_b = yjump_sub ? ylen : gda_pkg::acc_type'(dim_prev);
            alu_sub = 1'b0;
         end
         gda_pkg::ST_DIFF: begin
            if (phase_ff == gda_pkg::DIFF_LAST) begin
               alu_a = '0;
               alu_b = acc_ff;
               alu_sub = 1'b1;
            end else begin
               alu_a = acc_ff;
               alu_b = term;
               alu_sub = term_sub;
            end
         end
         default: begin
            alu_a = acc_ff;
            alu_b = '0;
            alu_sub = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;
      month_in = month_ff;
      year_in = year_ff;
      phase_in = phase_ff;
      item_in = item_ff;
      res_in = res_ff;
      case (state_ff)
         gda_pkg::ST_IDLE: begin
            if (req_fire) begin
               item_in = req_item;
               month_in = req_item.base_month;
               year_in = req_item.base_year;
               acc_in = alu_sum;
               phase_in = '0;
               if (req_err) begin
                  res_in = gda_pkg::RSP_ERROR;
                  state_in = gda_pkg::ST_DONE;
               end else begin
                  case (gda_pkg::func_type'(req_item.func))
                     gda_pkg::FUNC_ADD: state_in = gda_pkg::ST_ADD;
                     gda_pkg::FUNC_SUB: state_in = gda_pkg::ST_SUB;
                     default: begin
                        acc_in = '0;
                        state_in = gda_pkg::ST_DIFF;
                     end
                  endcase
               end
            end
         end
         gda_pkg::ST_ADD: begin
            if (yjump_add) begin
               acc_in = alu_sum;
               year_in = year_up;
               if (year_ff == gda_pkg::YEAR_MAX) begin
                  res_in = gda_pkg::RSP_ERROR;
                  state_in = gda_pkg::ST_DONE;
               end
            end else if (mstep_add) begin
               acc_in = alu_sum;
               if (month_ff == gda_pkg::MONTH_LAST) begin
                  month_in = gda_pkg::MONTH_FIRST;
                  year_in = year_up;
                  if (year_ff == gda_pkg::YEAR_MAX) begin
                     res_in = gda_pkg::RSP_ERROR;
                     state_in = gda_pkg::ST_DONE;
                  end
               end else begin
                  month_in = 4'(month_ff + 4'd1);
               end
            end else begin
               res_in = '{result_day: acc_ff[4:0], result_month: month_ff,
                          result_year: year_ff, day_count: 22'd0, error_flag: 1'b0};
               state_in = gda_pkg::ST_DONE;
            end
         end
         gda_pkg::ST_SUB: begin
            if (acc_ff > gda_pkg::acc_type'(0)) begin
               res_in = '{result_day: acc_ff[4:0], result_month: month_ff,
                          result_year: year_ff, day_count: 22'd0, error_flag: 1'b0};
               state_in = gda_pkg::ST_DONE;
            end else if (yjump_sub || (month_ff == gda_pkg::MONTH_FIRST)) begin
               if (year_ff == gda_pkg::YEAR_MIN) begin
                  res_in = gda_pkg::RSP_ERROR;
                  state_in = gda_pkg::ST_DONE;
               end else begin
                  acc_in = alu_sum;
                  year_in = year_dn;
                  month_in = yjump_sub ? month_ff : month_prev;
               end
            end else begin
               acc_in = alu_sum;
               month_in = month_prev;
            end
         end
         gda_pkg::ST_DIFF: begin
            if (phase_ff == gda_pkg::DIFF_LAST) begin
               res_in = '{result_day: 5'd0, result_month: 4'd0, result_year: 14'd0,
                          day_count: acc_ff[ACC_MSB] ? alu_sum[21:0] : acc_ff[21:0],
                          error_flag: 1'b0};
               state_in = gda_pkg::ST_DONE;
            end else begin
               acc_in = alu_sum;
               phase_in = 4'(phase_ff + 4'd1);
            end
         end
         gda_pkg::ST_DONE: begin
            if (take) begin
               state_in = gda_pkg::ST_IDLE;
            end
         end
         default: state_in = gda_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      month_ff <= month_in;
      year_ff <= year_in;
      phase_ff <= phase_in;
      item_ff <= item_in;
      res_ff <= res_in;
   end

   assign idle = (state_ff == gda_pkg::ST_IDLE);
   assign status = '{done: (state_ff == gda_pkg::ST_DONE), result: res_ff};

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == gda_pkg::ST_ADD || state_ff == gda_pkg::ST_SUB) |->
         (month_ff >= gda_pkg::MONTH_FIRST && month_ff <= gda_pkg::MONTH_LAST
          && year_ff >= gda_pkg::YEAR_MIN && year_ff <= gda_pkg::YEAR_MAX))
      else $error("date register left its range while stepping");

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != gda_pkg::ST_IDLE))
      else $error("accepted item did not start the sequencer");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == gda_pkg::ST_DIFF) |-> (phase_ff <= gda_pkg::DIFF_LAST))
      else $error("day-difference phase overran");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == gda_pkg::ST_SUB && acc_ff > gda_pkg::acc_type'(0))
         |=> (state_ff == gda_pkg::ST_DONE))
      else $error("subtract did not finish on a positive day");

endmodule

@@ sv/gregorian_date_arithmetic.sv @@
// Top level of the Gregorian date arithmetic block: request channel, sequencer, response register.
//
// Requests arrive on req_if (valid/ready); each item carries an operation (add days,
// subtract days, days between two dates), a base date, a day offset and a second date.
// Every item gives exactly one item on rsp_if: the resulting date, or the absolute day
// difference, plus an error flag that zeroes all other fields.
// One item is worked at a time; req_if.ready is high only while the sequencer is idle.
// Add and subtract first apply the offset to the base day, then step a whole year or
// a month at a time (at most twelve months) until the day fits, then finish and load the
// output. Days-between sums five serial-day terms per date with opposite signs, then
// takes the absolute value; an item rejected on its fields goes straight to done. All
// steps run through the single shared adder.
// The response sits in an output register; the next item is accepted while it waits.
// If the receiver stalls with a result still held, a finished item waits in the
// sequencer and no further item is accepted until the register frees.
// Synchronous reset returns the sequencer to idle and empties the output register.
module gregorian_date_arithmetic (
   input logic       clock,
   input logic       reset,
   gda_req_if.sink   req_if,
   gda_rsp_if.source rsp_if
);

   gda_pkg::req_type        req_item;
   logic                    req_fire;
   logic                    seq_idle;
   logic                    slot_free;
   gda_pkg::seq_status_type seq_status;

   logic                    rsp_valid_ff, rsp_valid_in;
   gda_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   assign req_item = '{
      func: req_if.func, base_day: req_if.base_day, base_month: req_if.base_month,
      base_year: req_if.base_year, offset_days: req_if.offset_days,
      other_day: req_if.other_day, other_month: req_if.other_month,
      other_year: req_if.other_year
   };

   assign req_if.ready = seq_idle;
   assign req_fire = req_if.valid && seq_idle;
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   gda_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .req_fire (req_fire),
      .idle     (seq_idle),
      .status   (seq_status),
      .take     (slot_free)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (seq_status.done && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = seq_status.result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.result_day = rsp_data_ff.result_day;
   assign rsp_if.result_month = rsp_data_ff.result_month;
   assign rsp_if.result_year = rsp_data_ff.result_year;
   assign rsp_if.day_count = rsp_data_ff.day_count;
   assign rsp_if.error_flag = rsp_data_ff.error_flag;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.error_flag) |->
         (rsp_data_ff.result_day == 5'd0 && rsp_data_ff.result_month == 4'd0
          && rsp_data_ff.result_year == 14'd0 && rsp_data_ff.day_count == 22'd0))
      else $error("error item carries nonzero fields");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.error_flag && rsp_data_ff.day_count != 22'd0)
         |-> (rsp_data_ff.result_month == 4'd0 && rsp_data_ff.result_year == 14'd0))
      else $error("day difference item carries a date");

endmodule
